// File: rtl/xs128p_pkg.sv
// Shared types, command codes and constants for the xorshift128+ generator.
// Used by the controller, the datapath and the top level.
package xs128p_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_ONE  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_TWO  = 64'h94D049BB133111EB;

  localparam int unsigned XS_SHL_P  = 23;
  localparam int unsigned XS_SHR_P  = 17;
  localparam int unsigned XS_SHR_Q  = 26;
  localparam int unsigned MIX_SHR_0 = 30;
  localparam int unsigned MIX_SHR_1 = 27;
  localparam int unsigned MIX_SHR_2 = 31;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED_ADDR = '0;

  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 120;

  // Operation codes carried on the input selector
  localparam logic [1:0] OPER_RESEED = 2'd0;
  localparam logic [1:0] OPER_WORD   = 2'd1;
  localparam logic [1:0] OPER_FRAC   = 2'd2;
  localparam logic [1:0] OPER_RANGED = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CNT_SEED,
    OP_CNT_ZERO,
    OP_CNT_INC,
    OP_MIX_PRE,
    OP_MIX_MID,
    OP_STORE_A,
    OP_STORE_B,
    OP_FIX_ZERO,
    OP_ADVANCE,
    OP_OUT_LOAD
  } dp_op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ZL_KL,
    MUL_ZL_KH,
    MUL_ZH_KL,
    MUL_FL_SPAN,
    MUL_FH_SPAN
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     k_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       empty;
  } dp_status_t;

endpackage

// File: rtl/xorshift128plus_generator_unit.sv
// Channel   | Dir | Handshake           | Payload
// s_*       | in  | s_tvalid / s_tready | tuser: operation; tdata: range_min, range_max
// m_*       | out | m_tvalid / m_tready | tuser: kind; tdata: word, fraction, ranged
// APB       | in  | psel, penable       | seed_value at byte address 0 (64 bits)
//
// m_tvalid rises and s_tready returns as the controller leaves ST_OUT, which a word
// or fraction draw reaches via ST_DECODE and ST_ADVANCE; a ranged draw also passes
// ST_RANGE_MUL (two partial products through the shared 33x33 multiplier), and an
// empty range goes from ST_DECODE straight to ST_OUT. A reseed holds s_tready low
// for two splitmix64 steps, each with two 64-bit multiplies on the multiplier.
// After reset the state is seeded from zero before s_tready rises. A result waits
// in the output register; the next item is taken meanwhile and stalls only when
// its own result is ready before the previous one is taken.
// Top level; depends on xs128p_pkg, xs128p_ctrl and xs128p_datapath.
module xorshift128plus_generator_unit import xs128p_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // [31:0] range_min, [63:32] range_max
  input  logic [1:0]            s_tuser,  // [1:0] operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,  // [31:0] word, [84:32] fraction,
                                          // [116:85] ranged, [119:117] zero
  output logic [1:0]            m_tuser,  // [1:0] kind
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [63:0] seed_value;
  logic        cfg_write;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [31:0] out_word;
  logic [52:0] out_fraction;
  logic [31:0] out_ranged;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == REG_SEED_ADDR) ? seed_value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
    end else if (cfg_write && paddr == REG_SEED_ADDR) begin
      seed_value <= pwdata;
    end
  end

  xs128p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  xs128p_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .seed_value   (seed_value),
    .in_operation (s_tuser),
    .in_range_min (s_tdata[31:0]),
    .in_range_max (s_tdata[63:32]),
    .out_kind     (m_tuser),
    .out_word     (out_word),
    .out_fraction (out_fraction),
    .out_ranged   (out_ranged)
  );

  assign m_tdata = {3'b000, out_ranged, out_fraction, out_word};

endmodule

// File: rtl/xs128p_datapath.sv
// Datapath of the xorshift128+ generator: state words, splitmix counter,
// shared 33x33 multiplier with accumulator, and the result register.
// Depends on xs128p_pkg.
module xs128p_datapath import xs128p_pkg::*; (
  input  logic              clk,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [63:0]       seed_value,
  input  logic [1:0]        in_operation,
  input  logic [31:0]       in_range_min,
  input  logic [31:0]       in_range_max,
  output logic [1:0]        out_kind,
  output logic [31:0]       out_word,
  output logic [52:0]       out_fraction,
  output logic [31:0]       out_ranged
);

  logic [63:0] state_a;
  logic [63:0] state_b;
  logic [63:0] counter;
  logic [63:0] mix_z;
  logic [63:0] draw;
  logic [65:0] prod;
  logic [85:0] acc;
  logic [1:0]  operation;
  logic [31:0] range_min;
  logic [32:0] span;
  logic        empty;

  logic [63:0] k_const;
  logic [32:0] mul_a;
  logic [32:0] mul_b;
  logic [63:0] xs_t1;
  logic [63:0] xs_t2;
  logic [63:0] xs_new_b;
  logic [63:0] xs_sum;
  logic [32:0] span_calc;
  logic [63:0] acc_lo;

  assign k_const = cmd.k_sel ? MIX_MUL_TWO : MIX_MUL_ONE;
  assign acc_lo  = acc[63:0];

  always_comb begin
    case (cmd.mul_sel)
      MUL_ZL_KL: begin
        mul_a = {1'b0, mix_z[31:0]};
        mul_b = {1'b0, k_const[31:0]};
      end
      MUL_ZL_KH: begin
        mul_a = {1'b0, mix_z[31:0]};
        mul_b = {1'b0, k_const[63:32]};
      end
      MUL_ZH_KL: begin
        mul_a = {1'b0, mix_z[63:32]};
        mul_b = {1'b0, k_const[31:0]};
      end
      MUL_FL_SPAN: begin
        mul_a = {1'b0, draw[42:11]};
        mul_b = span;
      end
      MUL_FH_SPAN: begin
        mul_a = {12'b0, draw[63:43]};
        mul_b = span;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // One xorshift128+ step
  always_comb begin
    xs_t1    = state_a ^ (state_a << XS_SHL_P);
    xs_t2    = xs_t1 ^ (xs_t1 >> XS_SHR_P);
    xs_new_b = xs_t2 ^ state_b ^ (state_b >> XS_SHR_Q);
    xs_sum   = xs_new_b + state_b;
  end

  assign span_calc = {in_range_max[31], in_range_max} - {in_range_min[31], in_range_min}
                     + 33'd1;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    case (cmd.acc_op)
      ACC_LOAD:   acc <= {20'b0, prod};
      ACC_ADD_HI: acc <= acc + {prod[53:0], 32'b0};
      default:    acc <= acc;
    endcase

    case (cmd.op)
      OP_CAPTURE: begin
        operation <= in_operation;
        range_min <= in_range_min;
        span      <= span_calc;
        empty     <= ($signed(in_range_max) <= $signed(in_range_min));
      end
      OP_CNT_SEED: counter <= seed_value + GOLDEN_GAMMA;
      OP_CNT_ZERO: counter <= GOLDEN_GAMMA;
      OP_CNT_INC:  counter <= counter + GOLDEN_GAMMA;
      OP_MIX_PRE:  mix_z   <= counter ^ (counter >> MIX_SHR_0);
      OP_MIX_MID:  mix_z   <= acc_lo ^ (acc_lo >> MIX_SHR_1);
      OP_STORE_A:  state_a <= acc_lo ^ (acc_lo >> MIX_SHR_2);
      OP_STORE_B:  state_b <= acc_lo ^ (acc_lo >> MIX_SHR_2);
      OP_FIX_ZERO: begin
        if (state_a == '0 && state_b == '0) begin
          state_a <= GOLDEN_GAMMA;
        end
      end
      OP_ADVANCE: begin
        state_a <= state_b;
        state_b <= xs_new_b;
        draw    <= xs_sum;
      end
      OP_OUT_LOAD: begin
        out_kind     <= operation;
        out_word     <= (operation == OPER_WORD) ? draw[63:32] : '0;
        out_fraction <= (operation == OPER_FRAC) ? draw[63:11] : '0;
        if (operation != OPER_RANGED) begin
          out_ranged <= '0;
        end else if (empty) begin
          out_ranged <= range_min;
        end else begin
          out_ranged <= range_min + acc[84:53];
        end
      end
      default: begin
      end
    endcase
  end

  assign status.operation = operation;
  assign status.empty     = empty;

endmodule

// File: rtl/xs128p_ctrl.sv
// Controller of the xorshift128+ generator: sequences seeding, draws and the
// shared multiplier, and owns the stream handshakes. Depends on xs128p_pkg.
module xs128p_ctrl import xs128p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEED_LOAD,
    ST_MIX_PRE,
    ST_MIX_MUL,
    ST_MIX_MID,
    ST_STORE,
    ST_CNT_INC,
    ST_FIX,
    ST_ADVANCE,
    ST_RANGE_MUL,
    ST_OUT
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] mul_cnt;
  logic [1:0] mul_cnt_next;
  logic       k_bit;
  logic       k_bit_next;
  logic       word_bit;
  logic       word_bit_next;
  logic       seed_zero;
  logic       seed_zero_next;
  logic       m_tvalid_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd            = '{op: OP_NONE, mul_sel: MUL_NONE, acc_op: ACC_HOLD, k_sel: k_bit};
    state_next     = state;
    mul_cnt_next   = mul_cnt;
    k_bit_next     = k_bit;
    word_bit_next  = word_bit;
    seed_zero_next = seed_zero;
    m_tvalid_next  = m_tvalid && !m_tready;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_CAPTURE;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.operation == OPER_RESEED) begin
          seed_zero_next = 1'b0;
          state_next     = ST_SEED_LOAD;
        end else if (status.operation == OPER_RANGED && status.empty) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_ADVANCE;
        end
      end
      ST_SEED_LOAD: begin
        cmd.op        = seed_zero ? OP_CNT_ZERO : OP_CNT_SEED;
        word_bit_next = 1'b0;
        state_next    = ST_MIX_PRE;
      end
      ST_MIX_PRE: begin
        cmd.op       = OP_MIX_PRE;
        k_bit_next   = 1'b0;
        mul_cnt_next = '0;
        state_next   = ST_MIX_MUL;
      end
      ST_MIX_MUL: begin
        // 64x64 low product from three 32x32 partials
        mul_cnt_next = mul_cnt + 2'd1;
        case (mul_cnt)
          2'd0: cmd.mul_sel = MUL_ZL_KL;
          2'd1: begin
            cmd.mul_sel = MUL_ZL_KH;
            cmd.acc_op  = ACC_LOAD;
          end
          2'd2: begin
            cmd.mul_sel = MUL_ZH_KL;
            cmd.acc_op  = ACC_ADD_HI;
          end
          default: begin
            cmd.acc_op   = ACC_ADD_HI;
            mul_cnt_next = '0;
            state_next   = k_bit ? ST_STORE : ST_MIX_MID;
          end
        endcase
      end
      ST_MIX_MID: begin
        cmd.op     = OP_MIX_MID;
        k_bit_next = 1'b1;
        state_next = ST_MIX_MUL;
      end
      ST_STORE: begin
        cmd.op = word_bit ? OP_STORE_B : OP_STORE_A;
        if (word_bit) begin
          state_next = ST_FIX;
        end else begin
          word_bit_next = 1'b1;
          state_next    = ST_CNT_INC;
        end
      end
      ST_CNT_INC: begin
        cmd.op     = OP_CNT_INC;
        state_next = ST_MIX_PRE;
      end
      ST_FIX: begin
        cmd.op     = OP_FIX_ZERO;
        state_next = ST_IDLE;
      end
      ST_ADVANCE: begin
        cmd.op       = OP_ADVANCE;
        mul_cnt_next = '0;
        state_next   = (status.operation == OPER_RANGED) ? ST_RANGE_MUL : ST_OUT;
      end
      ST_RANGE_MUL: begin
        mul_cnt_next = mul_cnt + 2'd1;
        case (mul_cnt)
          2'd0: cmd.mul_sel = MUL_FL_SPAN;
          2'd1: begin
            cmd.mul_sel = MUL_FH_SPAN;
            cmd.acc_op  = ACC_LOAD;
          end
          default: begin
            cmd.acc_op   = ACC_ADD_HI;
            mul_cnt_next = '0;
            state_next   = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          cmd.op        = OP_OUT_LOAD;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SEED_LOAD;
      mul_cnt   <= '0;
      k_bit     <= 1'b0;
      word_bit  <= 1'b0;
      seed_zero <= 1'b1;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      mul_cnt   <= mul_cnt_next;
      k_bit     <= k_bit_next;
      word_bit  <= word_bit_next;
      seed_zero <= seed_zero_next;
      m_tvalid  <= m_tvalid_next;
    end
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT_LOAD |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transfer");

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_DECODE)
    else $error("accepted transfer not decoded");

  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input taken before initial seeding");

endmodule
